// ===== design/analog_keypad_press_classifier_macros.svh =====
// Assertion macros shared by the keypad classifier RTL.
`ifndef ANALOG_KEYPAD_PRESS_CLASSIFIER_MACROS_SVH
`define ANALOG_KEYPAD_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AKPC_ASSERT_NOW(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("keypad classifier check failed");

// Next-cycle implication, checked out of reset.
`define AKPC_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("keypad classifier check failed");

`endif

// ===== design/akpc_pkg.sv =====
// Types and constants of the keypad press classifier.
package akpc_pkg;

    localparam int ADDR_W = 5;
    localparam int CFG_W  = 16;

    typedef enum logic [2:0] {
        REG_DOWN   = 3'd0,
        REG_LEFT   = 3'd1,
        REG_UP     = 3'd2,
        REG_RIGHT  = 3'd3,
        REG_SELECT = 3'd4,
        REG_SHORT  = 3'd5,
        REG_LONG   = 3'd6,
        REG_GAP    = 3'd7
    } akpc_reg_t;

    typedef enum logic [2:0] {
        BTN_NONE   = 3'd0,
        BTN_DOWN   = 3'd1,
        BTN_LEFT   = 3'd2,
        BTN_UP     = 3'd3,
        BTN_RIGHT  = 3'd4,
        BTN_SELECT = 3'd5
    } akpc_key_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_PRESS   = 2'd1,
        ACT_LONG    = 2'd2,
        ACT_RELEASE = 2'd3
    } akpc_action_t;

    localparam logic [CFG_W-1:0] RST_DOWN   = 16'd9830;
    localparam logic [CFG_W-1:0] RST_LEFT   = 16'd26214;
    localparam logic [CFG_W-1:0] RST_UP     = 16'd45874;
    localparam logic [CFG_W-1:0] RST_RIGHT  = 16'd65535;
    localparam logic [CFG_W-1:0] RST_SELECT = 16'd0;
    localparam logic [CFG_W-1:0] RST_SHORT  = 16'd10;
    localparam logic [CFG_W-1:0] RST_LONG   = 16'd1000;
    localparam logic [CFG_W-1:0] RST_GAP    = 16'd25;

    typedef struct packed {
        logic [CFG_W-1:0] down_threshold;
        logic [CFG_W-1:0] left_threshold;
        logic [CFG_W-1:0] up_threshold;
        logic [CFG_W-1:0] right_threshold;
        logic [CFG_W-1:0] select_threshold;
        logic [CFG_W-1:0] short_press_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] inter_key_ms;
    } akpc_cfg_t;

    typedef struct packed {
        akpc_action_t event_action;
        akpc_key_t    event_key;
    } akpc_result_t;

endpackage

// ===== design/akpc_cfg.sv =====
// APB register file holding thresholds and timing settings.
module akpc_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [akpc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output akpc_pkg::akpc_cfg_t         cfg
);
    import akpc_pkg::*;

    akpc_cfg_t              cfg_reg;
    akpc_cfg_t              cfg_next;
    akpc_reg_t              index;
    logic                   wr_en;
    logic [CFG_W-1:0]       wdata;
    logic [CFG_W-1:0]       rdata;

    assign pready = 1'b1;
    assign index  = akpc_reg_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign wdata  = pwdata[CFG_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_DOWN:   cfg_next.down_threshold   = wdata;
                REG_LEFT:   cfg_next.left_threshold   = wdata;
                REG_UP:     cfg_next.up_threshold     = wdata;
                REG_RIGHT:  cfg_next.right_threshold  = wdata;
                REG_SELECT: cfg_next.select_threshold = wdata;
                REG_SHORT:  cfg_next.short_press_ms   = wdata;
                REG_LONG:   cfg_next.long_press_ms    = wdata;
                REG_GAP:    cfg_next.inter_key_ms     = wdata;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_DOWN:   rdata = cfg_reg.down_threshold;
            REG_LEFT:   rdata = cfg_reg.left_threshold;
            REG_UP:     rdata = cfg_reg.up_threshold;
            REG_RIGHT:  rdata = cfg_reg.right_threshold;
            REG_SELECT: rdata = cfg_reg.select_threshold;
            REG_SHORT:  rdata = cfg_reg.short_press_ms;
            REG_LONG:   rdata = cfg_reg.long_press_ms;
            REG_GAP:    rdata = cfg_reg.inter_key_ms;
            default:    rdata = '0;
        endcase
    end

    assign prdata = {{(32-CFG_W){1'b0}}, rdata};
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.down_threshold   <= RST_DOWN;
            cfg_reg.left_threshold   <= RST_LEFT;
            cfg_reg.up_threshold     <= RST_UP;
            cfg_reg.right_threshold  <= RST_RIGHT;
            cfg_reg.select_threshold <= RST_SELECT;
            cfg_reg.short_press_ms   <= RST_SHORT;
            cfg_reg.long_press_ms    <= RST_LONG;
            cfg_reg.inter_key_ms     <= RST_GAP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/akpc_judge.sv =====
// Per-sample key classification, timer advance and event decision.
module akpc_judge
#(
    parameter int TIMER_BITS  = 16,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic [15:0]                  adc_sample,
    input  logic [9:0]                   elapsed_ms,
    input  akpc_pkg::akpc_cfg_t          cfg,
    input  akpc_pkg::akpc_key_t          held_key,
    input  akpc_pkg::akpc_action_t       held_action,
    input  logic [TIMER_BITS-1:0]        hold_ms,
    input  logic                         hold_running,
    input  logic [TIMER_BITS-1:0]        gap_ms,
    input  logic                         gap_running,
    output akpc_pkg::akpc_key_t          held_key_next,
    output akpc_pkg::akpc_action_t       held_action_next,
    output logic [TIMER_BITS-1:0]        hold_ms_next,
    output logic                         hold_running_next,
    output logic [TIMER_BITS-1:0]        gap_ms_next,
    output logic                         gap_running_next,
    output akpc_pkg::akpc_result_t       result
);
    import akpc_pkg::*;

    localparam int SUM_W = ((TIMER_BITS > 10) ? TIMER_BITS : 10) + 1;
    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [15:0] SAMPLE_MASK = 16'((33'd1 << SAMPLE_BITS) - 33'd1);

    logic [15:0]           sample;
    akpc_key_t             key;
    logic [SUM_W-1:0]      hold_sum;
    logic [SUM_W-1:0]      gap_sum;
    logic [TIMER_BITS-1:0] hold_adv;
    logic [TIMER_BITS-1:0] gap_adv;
    logic                  lockout;

    assign sample = adc_sample & SAMPLE_MASK;

    // First threshold the sample lies below wins.
    always_comb
    begin
        if (sample < cfg.down_threshold)
            key = BTN_DOWN;
        else if (sample < cfg.left_threshold)
            key = BTN_LEFT;
        else if (sample < cfg.up_threshold)
            key = BTN_UP;
        else if (sample < cfg.right_threshold)
            key = BTN_RIGHT;
        else if (sample < cfg.select_threshold)
            key = BTN_SELECT;
        else
            key = BTN_NONE;
    end

    // Advance running timers, saturating at all ones.
    assign hold_sum = SUM_W'(hold_ms) + SUM_W'(elapsed_ms);
    assign gap_sum  = SUM_W'(gap_ms) + SUM_W'(elapsed_ms);

    always_comb
    begin
        hold_adv = hold_ms;
        gap_adv  = gap_ms;
        if (hold_running)
            hold_adv = (|hold_sum[SUM_W-1:TIMER_BITS]) ? '1 : hold_sum[TIMER_BITS-1:0];
        if (gap_running)
            gap_adv = (|gap_sum[SUM_W-1:TIMER_BITS]) ? '1 : gap_sum[TIMER_BITS-1:0];
    end

    always_comb
    begin
        held_key_next     = held_key;
        held_action_next  = held_action;
        hold_ms_next      = hold_adv;
        hold_running_next = hold_running;
        gap_ms_next       = gap_adv;
        gap_running_next  = gap_running;
        result.event_key    = BTN_NONE;
        result.event_action = ACT_NONE;
        lockout           = 1'b0;

        // Hold off new events until the gap expires, then clear the old key.
        if (held_action == ACT_RELEASE)
        begin
            if (CMP_W'(gap_adv) < CMP_W'(cfg.inter_key_ms))
            begin
                lockout = 1'b1;
            end
            else
            begin
                held_key_next    = BTN_NONE;
                held_action_next = ACT_NONE;
                gap_running_next = 1'b0;
                gap_ms_next      = '0;
            end
        end

        if (!lockout)
        begin
            if (key != held_key_next || key == BTN_NONE)
            begin
                hold_running_next = 1'b0;
                hold_ms_next      = '0;
                if (held_action_next != ACT_NONE)
                begin
                    result.event_key    = held_key_next;
                    result.event_action = ACT_RELEASE;
                    held_action_next    = ACT_RELEASE;
                    gap_running_next    = 1'b1;
                end
                else
                begin
                    hold_running_next = (key != BTN_NONE);
                    held_key_next     = key;
                end
            end
            else if (held_action_next == ACT_NONE &&
                     CMP_W'(hold_adv) >= CMP_W'(cfg.short_press_ms))
            begin
                held_action_next    = ACT_PRESS;
                result.event_key    = held_key_next;
                result.event_action = ACT_PRESS;
            end
            else if (held_action_next == ACT_PRESS &&
                     CMP_W'(hold_adv) >= CMP_W'(cfg.long_press_ms))
            begin
                held_action_next    = ACT_LONG;
                hold_running_next   = 1'b0;
                result.event_key    = held_key_next;
                result.event_action = ACT_LONG;
            end
        end
    end

endmodule

// ===== design/analog_keypad_press_classifier.sv =====
// An accepted sample waits in the input register until the result register is free;
// one sample per cycle while m_tready drains it. The key decision sits between the
// input and result registers; key state is committed in the same cycle as the result.
// s_tready stays high while the result register is free or being drained.
// Reset (rst_n low, asynchronous) clears key state, timers, both valid flags
// and restores the register defaults.
`include "analog_keypad_press_classifier_macros.svh"

module analog_keypad_press_classifier
#(
    parameter int TIMER_BITS  = 16,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [akpc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // adc_sample[15:0], elapsed_ms[25:16]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata    // event_key[2:0], event_action[4:3]
);
    import akpc_pkg::*;

    akpc_cfg_t             cfg;

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [15:0]           in_sample_reg;
    logic [9:0]            in_elapsed_reg;

    akpc_key_t             held_key_reg;
    akpc_key_t             held_key_next;
    akpc_action_t          held_action_reg;
    akpc_action_t          held_action_next;
    logic [TIMER_BITS-1:0] hold_ms_reg;
    logic [TIMER_BITS-1:0] hold_ms_next;
    logic                  hold_running_reg;
    logic                  hold_running_next;
    logic [TIMER_BITS-1:0] gap_ms_reg;
    logic [TIMER_BITS-1:0] gap_ms_next;
    logic                  gap_running_reg;
    logic                  gap_running_next;

    akpc_result_t          result;
    akpc_result_t          out_result_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic                  in_xfer;
    logic                  out_free;
    logic                  advance;

    akpc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    akpc_judge #(
        .TIMER_BITS  (TIMER_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_judge (
        .adc_sample        (in_sample_reg),
        .elapsed_ms        (in_elapsed_reg),
        .cfg               (cfg),
        .held_key          (held_key_reg),
        .held_action       (held_action_reg),
        .hold_ms           (hold_ms_reg),
        .hold_running      (hold_running_reg),
        .gap_ms            (gap_ms_reg),
        .gap_running       (gap_running_reg),
        .held_key_next     (held_key_next),
        .held_action_next  (held_action_next),
        .hold_ms_next      (hold_ms_next),
        .hold_running_next (hold_running_next),
        .gap_ms_next       (gap_ms_next),
        .gap_running_next  (gap_running_next),
        .result            (result)
    );

    // Result slot frees when empty or drained this cycle.
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign in_xfer   = s_tvalid && s_tready;

    assign in_valid_next  = in_xfer || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_result_reg.event_action, out_result_reg.event_key};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            held_key_reg     <= BTN_NONE;
            held_action_reg  <= ACT_NONE;
            hold_ms_reg      <= '0;
            hold_running_reg <= 1'b0;
            gap_ms_reg       <= '0;
            gap_running_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            // Commit key state only when the sample moves into the result slot.
            if (advance)
            begin
                held_key_reg     <= held_key_next;
                held_action_reg  <= held_action_next;
                hold_ms_reg      <= hold_ms_next;
                hold_running_reg <= hold_running_next;
                gap_ms_reg       <= gap_ms_next;
                gap_running_reg  <= gap_running_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_sample_reg  <= s_tdata[15:0];
            in_elapsed_reg <= s_tdata[25:16];
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    `AKPC_ASSERT_NOW(a_quiet_key_zero, clk, rst_n, out_valid_reg && out_result_reg.event_action == ACT_NONE, out_result_reg.event_key == BTN_NONE)
    `AKPC_ASSERT_NOW(a_long_stops_hold, clk, rst_n, held_action_reg == ACT_LONG, !hold_running_reg)
    `AKPC_ASSERT_NOW(a_gap_only_released, clk, rst_n, gap_running_reg, held_action_reg == ACT_RELEASE)
    `AKPC_ASSERT_NOW(a_hold_has_key, clk, rst_n, hold_running_reg, held_key_reg != BTN_NONE)
    `AKPC_ASSERT_NEXT(a_state_frozen, clk, rst_n, !advance, $stable(held_key_reg) && $stable(held_action_reg) && $stable(hold_ms_reg))

endmodule
